// File: hw/rtl/tet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tet_pkg
// shared constants, types and the quarter-wave sine table of the end taper
// ----------------------------------------------------------------------------
package tet_pkg;

  localparam int SAMPLE_WIDTH         = 24;
  localparam int MAX_TRACE_LENGTH     = 65536;
  localparam int ANGLE_BITS           = 10;
  localparam int WEIGHT_FRACTION_BITS = 16;

  localparam int LEN_W  = 17;
  localparam int POS_W  = 16;
  localparam int KIND_W = 3;
  localparam int IDX_W  = 2;
  localparam int W_W    = WEIGHT_FRACTION_BITS + 1;
  localparam int ADDR_W = ANGLE_BITS + 1;
  localparam int NUM_W  = POS_W + ANGLE_BITS + 3;
  localparam int DEN_W  = POS_W + 1;
  localparam int CNT_W  = $clog2(NUM_W);
  localparam int QTR    = 1 << ANGLE_BITS;

  localparam logic [W_W-1:0] ONE_W  = W_W'(1 << WEIGHT_FRACTION_BITS);
  localparam logic [W_W-1:0] HALF_W = W_W'(1 << (WEIGHT_FRACTION_BITS - 1));
  localparam logic [W_W-1:0] HAM_A  =
    W_W'(((54 << WEIGHT_FRACTION_BITS) + 50) / 100);
  localparam logic [W_W-1:0] HAM_B  =
    W_W'(((46 << WEIGHT_FRACTION_BITS) + 50) / 100);

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TRACE_LENGTH);

  localparam logic [KIND_W-1:0] TAPER_SINE    = 3'd0;
  localparam logic [KIND_W-1:0] TAPER_ONE_COS = 3'd1;
  localparam logic [KIND_W-1:0] TAPER_HANNING = 3'd2;
  localparam logic [KIND_W-1:0] TAPER_HAMMING = 3'd3;
  localparam logic [KIND_W-1:0] TAPER_NONE    = 3'd4;

  localparam logic [IDX_W-1:0] REG_RECORD_LENGTH = 2'd0;
  localparam logic [IDX_W-1:0] REG_TAPER_POINTS  = 2'd1;
  localparam logic [IDX_W-1:0] REG_TAPER_TYPE    = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic [POS_W-1:0]               dist_left;
    logic [POS_W-1:0]               dist_right;
    logic [POS_W-1:0]               tlen;
    logic [KIND_W-1:0]              kind;
    logic                           last;
  } tet_item_t;

  typedef enum logic [2:0] {
    B_IDLE, B_SETUP, B_DIV, B_ROM, B_WGT, B_MUL, B_DONE
  } back_state_t;

  typedef logic [W_W-1:0] sine_tab_t [0:QTR];

  function automatic sine_tab_t build_sine();
    sine_tab_t           tab;
    longint unsigned     x;
    longint unsigned     x2;
    longint unsigned     t;
    longint              sum;
    longint unsigned     r;
    for (int k = 0; k <= QTR; k++) begin
      x   = (64'd1686629713 * longint'(k)) >> ANGLE_BITS;
      x2  = (x * x) >> 30;
      t   = x;
      sum = longint'(x);
      t = ((t * x2) >> 30) / 6;   sum = sum - longint'(t);
      t = ((t * x2) >> 30) / 20;  sum = sum + longint'(t);
      t = ((t * x2) >> 30) / 42;  sum = sum - longint'(t);
      t = ((t * x2) >> 30) / 72;  sum = sum + longint'(t);
      t = ((t * x2) >> 30) / 110; sum = sum - longint'(t);
      t = ((t * x2) >> 30) / 156; sum = sum + longint'(t);
      t = ((t * x2) >> 30) / 210; sum = sum - longint'(t);
      t = ((t * x2) >> 30) / 272; sum = sum + longint'(t);
      t = ((t * x2) >> 30) / 342; sum = sum - longint'(t);
      t = ((t * x2) >> 30) / 420; sum = sum + longint'(t);
      if (sum < 0) sum = 0;
      r = (longint'(sum) + (64'd1 << (29 - WEIGHT_FRACTION_BITS)))
          >> (30 - WEIGHT_FRACTION_BITS);
      if (r > longint'(ONE_W)) r = longint'(ONE_W);
      tab[k] = W_W'(r);
    end
    tab[0]   = '0;
    tab[QTR] = ONE_W;
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

// File: hw/rtl/trace_end_taper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trace_end_taper
// end taper of a seismic trace: each sample scaled by left and right weights
// ----------------------------------------------------------------------------
// Samples are taken one at a time. A sample inside a taper zone needs a
// bit-serial division per end, plus lookup, weight and multiply steps,
// while an end outside its zone skips straight to the multiply step; that
// divider sets the rate. A two-item queue lets the input side take samples
// while one is in work, and an output register holds a finished sample
// until it is taken.
module trace_end_taper import tet_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [LEN_W-1:0]        cfg_data,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [SAMPLE_WIDTH-1:0] s_tdata,   // sample_in
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [SAMPLE_WIDTH-1:0] m_tdata,   // sample_out
  output logic                    m_tlast
);

  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_valid;
  tet_item_t q_in;
  tet_item_t q_head;

  tet_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  tet_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  tet_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// File: hw/rtl/tet_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tet_front
// config registers, sample position and end distances for each item
// ----------------------------------------------------------------------------
module tet_front import tet_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [LEN_W-1:0]         cfg_data,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [SAMPLE_WIDTH-1:0]  s_tdata,
  input  logic                     q_full,
  output logic                     q_push,
  output tet_item_t                q_item
);

  logic [LEN_W-1:0]  record_length;
  logic [POS_W-1:0]  taper_points;
  logic [KIND_W-1:0] taper_type;
  logic [POS_W-1:0]  sample_position;
  logic [POS_W-1:0]  sample_position_next;

  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  len_m1;
  logic [LEN_W-1:0]  tp_eff;
  logic [LEN_W-1:0]  tlen;
  logic [LEN_W-1:0]  pos;
  logic              last;

  always_comb begin
    if (record_length == '0) begin
      len = LEN_W'(1);
    end else if (record_length > LEN_MAX) begin
      len = LEN_MAX;
    end else begin
      len = record_length;
    end
    len_m1 = len - LEN_W'(1);
    tp_eff = (taper_points < POS_W'(2)) ? LEN_W'(2) : LEN_W'(taper_points);
    tlen   = (tp_eff > len) ? len : tp_eff;
    pos    = (LEN_W'(sample_position) > len_m1) ? len_m1 : LEN_W'(sample_position);
    last   = (pos == len_m1);
    sample_position_next = last ? '0 : POS_W'(pos + LEN_W'(1));
  end

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;

  always_comb begin
    q_item.sample     = s_tdata;
    q_item.dist_left  = POS_W'(pos);
    q_item.dist_right = POS_W'(len_m1 - pos);
    q_item.tlen       = POS_W'(tlen);
    q_item.kind       = (taper_type > TAPER_HAMMING) ? TAPER_NONE : taper_type;
    q_item.last       = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_length   <= LEN_W'(1024);
      taper_points    <= POS_W'(2);
      taper_type      <= TAPER_SINE;
      sample_position <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RECORD_LENGTH: record_length <= cfg_data;
          REG_TAPER_POINTS:  taper_points  <= cfg_data[POS_W-1:0];
          REG_TAPER_TYPE:    taper_type    <= cfg_data[KIND_W-1:0];
          default: ;
        endcase
      end
      if (q_push) begin
        sample_position <= sample_position_next;
      end
    end
  end

endmodule

// File: hw/rtl/tet_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tet_queue
// two-entry item queue between front and back
// ----------------------------------------------------------------------------
module tet_queue import tet_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  tet_item_t push_item,
  input  logic      pop,
  output logic      full,
  output logic      not_empty,
  output tet_item_t head
);

  tet_item_t   entry [0:1];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: hw/rtl/tet_sine_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tet_sine_rom
// quarter-wave sine table, Q1.16, registered read
// ----------------------------------------------------------------------------
module tet_sine_rom import tet_pkg::*; (
  input  logic              clk,
  input  logic [ADDR_W-1:0] addr,
  output logic [W_W-1:0]    data
);

  always_ff @(posedge clk) begin
    data <= SINE_TAB[addr];
  end

endmodule

// File: hw/rtl/tet_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tet_back
// weight sequencer: serial divider, sine lookup, two weight multiplies
// ----------------------------------------------------------------------------
module tet_back import tet_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  input  tet_item_t                q_item,
  output logic                     q_pop,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [SAMPLE_WIDTH-1:0]  m_tdata,
  output logic                     m_tlast
);

  back_state_t state;
  back_state_t state_next;

  tet_item_t               item;
  logic                    side;
  logic                    neg_x;
  logic [SAMPLE_WIDTH-1:0] mag;
  logic [NUM_W-1:0]        num;
  logic [DEN_W-1:0]        den;
  logic [DEN_W-1:0]        rem;
  logic [CNT_W-1:0]        cnt;
  logic                    neg_c;
  logic [W_W-1:0]          weight;
  logic [ADDR_W-1:0]       rom_addr;
  logic [W_W-1:0]          rom_data;

  logic                    out_load;
  logic [POS_W-1:0]        end_dist;
  logic                    bypass;
  logic                    hann;
  logic [DEN_W:0]          rem_sh;
  logic                    ge;
  logic [ADDR_W-1:0]       i_clamp;
  logic [ADDR_W:0]         j_clamp;
  logic                    j_neg;
  logic [W_W-1:0]          coef_a;
  logic [W_W-1:0]          coef_b;
  logic [2*W_W-1:0]        bc;
  logic [W_W-1:0]          m_term;
  logic [W_W-1:0]          weight_calc;
  logic [SAMPLE_WIDTH+W_W-1:0] prod;
  logic [SAMPLE_WIDTH-1:0] y;

  tet_sine_rom u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  always_comb begin
    end_dist = side ? item.dist_right : item.dist_left;
    bypass   = (item.kind == TAPER_NONE) || (end_dist >= item.tlen);
    hann     = (item.kind == TAPER_HANNING) || (item.kind == TAPER_HAMMING);
    rem_sh   = {rem, num[NUM_W-1]};
    ge       = rem_sh >= {1'b0, den};

    i_clamp = (num > NUM_W'(QTR)) ? ADDR_W'(QTR) : num[ADDR_W-1:0];
    j_clamp = (num > NUM_W'(2 * QTR)) ? (ADDR_W + 1)'(2 * QTR) : num[ADDR_W:0];
    j_neg   = j_clamp > (ADDR_W + 1)'(QTR);
    if (hann) begin
      rom_addr = j_neg ? ADDR_W'(j_clamp - (ADDR_W + 1)'(QTR))
                       : ADDR_W'((ADDR_W + 1)'(QTR) - j_clamp);
    end else if (item.kind == TAPER_SINE) begin
      rom_addr = i_clamp;
    end else begin
      rom_addr = ADDR_W'(QTR) - i_clamp;
    end

    coef_a = (item.kind == TAPER_HAMMING) ? HAM_A : HALF_W;
    coef_b = (item.kind == TAPER_HAMMING) ? HAM_B : HALF_W;
    bc     = coef_b * rom_data + (2 * W_W)'(HALF_W);
    m_term = bc[WEIGHT_FRACTION_BITS +: W_W];
    if (hann) begin
      weight_calc = neg_c ? coef_a + m_term : coef_a - m_term;
    end else if (item.kind == TAPER_SINE) begin
      weight_calc = rom_data;
    end else begin
      weight_calc = ONE_W - rom_data;
    end

    prod = mag * weight + (SAMPLE_WIDTH + W_W)'(HALF_W);

    if (neg_x) begin
      y = -mag;
    end else if (mag[SAMPLE_WIDTH-1]) begin
      y = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    end else begin
      y = mag;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (q_valid) state_next = B_SETUP;
      B_SETUP: state_next = bypass ? B_MUL : B_DIV;
      B_DIV:   if (cnt == CNT_W'(NUM_W - 1)) state_next = B_ROM;
      B_ROM:   state_next = B_WGT;
      B_WGT:   state_next = B_MUL;
      B_MUL:   state_next = side ? B_DONE : B_SETUP;
      B_DONE:  if (out_load) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = (state == B_IDLE) && q_valid;
    out_load = (state == B_DONE) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        item  <= q_item;
        side  <= 1'b0;
        neg_x <= q_item.sample[SAMPLE_WIDTH-1];
        mag   <= q_item.sample[SAMPLE_WIDTH-1] ? -q_item.sample : q_item.sample;
      end
      B_SETUP: begin
        weight <= ONE_W;
        rem    <= '0;
        cnt    <= '0;
        den    <= {item.tlen, 1'b0};
        num    <= hann ? NUM_W'({end_dist, {(ANGLE_BITS + 2){1'b0}}}) + NUM_W'(item.tlen)
                       : NUM_W'({end_dist, {(ANGLE_BITS + 1){1'b0}}}) + NUM_W'(item.tlen);
      end
      B_DIV: begin
        rem <= ge ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
        num <= {num[NUM_W-2:0], ge};
        cnt <= cnt + CNT_W'(1);
      end
      B_ROM: begin
        neg_c <= hann && j_neg;
      end
      B_WGT: begin
        weight <= weight_calc;
      end
      B_MUL: begin
        mag  <= prod[WEIGHT_FRACTION_BITS +: SAMPLE_WIDTH];
        side <= 1'b1;
      end
      default: ;
    endcase
    if (out_load) begin
      m_tdata <= y;
      m_tlast <= item.last;
    end
  end

endmodule

// File: bench/trace_end_taper_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trace_end_taper_test
// self-checking bench: each sample is predicted in fixed point from the taper
// definition and compared with the block output, under random source gaps,
// sink stalls, one long sink hold-off and many register settings
// ----------------------------------------------------------------------------
module trace_end_taper_test;
  import tet_pkg::*;

  typedef struct {
    logic [SAMPLE_WIDTH-1:0] sample;
    logic                    last;
  } tapered_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [IDX_W-1:0]        cfg_index = '0;
  logic [LEN_W-1:0]        cfg_data = '0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [SAMPLE_WIDTH-1:0] s_tdata = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [SAMPLE_WIDTH-1:0] m_tdata;
  logic                    m_tlast;

  tapered_t        tapered_q[$];
  longint unsigned sine_q16[0:QTR];
  longint unsigned rec_len = 1024;
  longint unsigned taper_len = 2;
  longint unsigned taper_kind = 0;
  longint unsigned position = 0;
  int              errors = 0;
  int              sent = 0;
  int              taken = 0;
  int              cycles = 0;
  int              burst_left = 0;
  int              hold_cnt = 0;
  bit              hold_req = 0;
  bit              hold_done = 0;
  int              sink_mode = 0;

  trace_end_taper dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("trace_end_taper: mismatch");
      $finish;
    end
  end

  function automatic void build_sine_q16();
    longint unsigned x, x2, t, r;
    longint          sum;
    for (int k = 0; k <= QTR; k++) begin
      x   = (64'd1686629713 * k) >> ANGLE_BITS;
      x2  = (x * x) >> 30;
      t   = x;
      sum = x;
      for (int n = 1; n <= 10; n++) begin
        t = ((t * x2) >> 30) / ((2 * n) * (2 * n + 1));
        if (n % 2) sum -= t; else sum += t;
      end
      if (sum < 0) sum = 0;
      r = (sum + (64'd1 << (29 - WEIGHT_FRACTION_BITS))) >> (30 - WEIGHT_FRACTION_BITS);
      if (r > (64'd1 << WEIGHT_FRACTION_BITS)) r = 64'd1 << WEIGHT_FRACTION_BITS;
      sine_q16[k] = r;
    end
    sine_q16[0]   = 0;
    sine_q16[QTR] = 64'd1 << WEIGHT_FRACTION_BITS;
  endfunction

  function automatic longint unsigned end_weight(longint unsigned d, longint unsigned tl,
                                                 longint unsigned kind);
    longint unsigned one, i, a, b, c, m;
    one = 64'd1 << WEIGHT_FRACTION_BITS;
    if (kind > TAPER_HAMMING || d >= tl) return one;
    if (kind <= TAPER_ONE_COS) begin
      i = (2 * d * QTR + tl) / (2 * tl);
      if (i > QTR) i = QTR;
      return (kind == TAPER_SINE) ? sine_q16[i] : one - sine_q16[QTR - i];
    end
    if (kind == TAPER_HANNING) begin
      a = one >> 1;
      b = one >> 1;
    end else begin
      a = ((64'd54 << WEIGHT_FRACTION_BITS) + 50) / 100;
      b = ((64'd46 << WEIGHT_FRACTION_BITS) + 50) / 100;
    end
    i = (4 * d * QTR + tl) / (2 * tl);
    if (i > 2 * QTR) i = 2 * QTR;
    if (i <= QTR) begin
      c = sine_q16[QTR - i];
      m = (b * c + (one >> 1)) >> WEIGHT_FRACTION_BITS;
      return a - m;
    end
    c = sine_q16[i - QTR];
    m = (b * c + (one >> 1)) >> WEIGHT_FRACTION_BITS;
    return a + m;
  endfunction

  function automatic longint scale(longint x, longint unsigned w);
    longint unsigned mag, p;
    mag = (x < 0) ? -x : x;
    p = (mag * w + (64'd1 << (WEIGHT_FRACTION_BITS - 1))) >> WEIGHT_FRACTION_BITS;
    return (x < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic tapered_t taper_sample(logic [SAMPLE_WIDTH-1:0] raw);
    tapered_t        res;
    longint unsigned len, tl, pos;
    longint          x, y;
    longint          maxv;
    maxv = (64'd1 << (SAMPLE_WIDTH - 1)) - 1;
    len = (rec_len == 0) ? 1 : rec_len;
    if (len > MAX_TRACE_LENGTH) len = MAX_TRACE_LENGTH;
    tl = (taper_len < 2) ? 2 : taper_len;
    if (tl > len) tl = len;
    pos = (position > len - 1) ? len - 1 : position;
    x = longint'(signed'(raw));
    y = scale(x, end_weight(pos, tl, taper_kind));
    y = scale(y, end_weight(len - 1 - pos, tl, taper_kind));
    if (y > maxv) y = maxv;
    if (y < -maxv - 1) y = -maxv - 1;
    res.sample = y[SAMPLE_WIDTH-1:0];
    res.last = (pos + 1 >= len);
    position = res.last ? 0 : pos + 1;
    return res;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("error at item %0d: %s got %0h want %0h", taken, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (tapered_q.size() == 0) begin
        report("unexpected item", m_tdata, 0);
      end else begin
        if (m_tdata !== tapered_q[0].sample) report("sample", m_tdata, tapered_q[0].sample);
        if (m_tlast !== tapered_q[0].last) report("trace end", m_tlast, tapered_q[0].last);
        void'(tapered_q.pop_front());
      end
      taken++;
    end
  end

  always @(posedge clk) begin
    if (cycles % 64 == 0) sink_mode <= $urandom_range(0, 2);
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else if (!hold_done && hold_req) begin
      hold_done <= 1;
      hold_cnt <= 500;
      m_tready <= 1'b0;
    end else begin
      case (sink_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= $urandom_range(0, 1);
        default: m_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic send_item(logic [SAMPLE_WIDTH-1:0] x);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= x;
    do @(posedge clk); while (!s_tready);
    tapered_q.push_back(taper_sample(x));
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (tapered_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [LEN_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_RECORD_LENGTH: rec_len = val;
      REG_TAPER_POINTS:  taper_len = val[15:0];
      REG_TAPER_TYPE:    taper_kind = val[2:0];
      default: ;
    endcase
  endtask

  task automatic set_taper(logic [LEN_W-1:0] len, logic [LEN_W-1:0] tp,
                           logic [LEN_W-1:0] kind);
    drain();
    write_reg(REG_RECORD_LENGTH, len);
    write_reg(REG_TAPER_POINTS, tp);
    write_reg(REG_TAPER_TYPE, kind);
  endtask

  function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      1: return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      2: return SAMPLE_WIDTH'($urandom_range(0, 3)) - SAMPLE_WIDTH'(1);
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_item({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
    send_item({1'b1, {(SAMPLE_WIDTH-1){1'b0}}});
    send_item('1);
  endtask

  task automatic test_each_type();
    logic [SAMPLE_WIDTH-1:0] ext[4];
    ext = '{{1'b0, {(SAMPLE_WIDTH-1){1'b1}}}, {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}, '0, '1};
    for (int k = TAPER_SINE; k <= TAPER_NONE; k++) begin
      set_taper(LEN_W'(5), LEN_W'(2), LEN_W'(k));
      for (int i = 0; i < 5; i++) send_item(ext[i % 4]);
    end
  endtask

  task automatic test_corner_settings();
    set_taper(LEN_W'(0), LEN_W'(0), LEN_W'(7));
    send_item('1);
    drain();
    write_reg(REG_TAPER_TYPE, LEN_W'(TAPER_SINE));
    send_item({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
    set_taper(LEN_W'(9), LEN_W'(100), LEN_W'(TAPER_HAMMING));
    repeat (6) send_item({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
    drain();
    // position now past the new end
    write_reg(REG_RECORD_LENGTH, LEN_W'(3));
    send_item({1'b1, {(SAMPLE_WIDTH-1){1'b0}}});
    send_item(24'h123456);
    set_taper(LEN_W'(131071), LEN_W'(16'hffff), LEN_W'(TAPER_ONE_COS));
    repeat (3) send_item(pick_sample());
    set_taper(LEN_W'(MAX_TRACE_LENGTH), LEN_W'(32768), LEN_W'(TAPER_HANNING));
    repeat (3) send_item(pick_sample());
  endtask

  task automatic test_long_stall();
    hold_req <= 1'b1;
    repeat (12) send_item(pick_sample());
  endtask

  task automatic test_random_traces();
    int n;
    logic [LEN_W-1:0] len, tp;
    while (sent < 820) begin
      len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(0, 48));
      tp = ($urandom_range(0, 7) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(0, 24));
      set_taper(len, tp, LEN_W'($urandom_range(0, 7)));
      n = (len > 0 && len <= 48) ? int'(len) * $urandom_range(1, 2) : $urandom_range(1, 30);
      repeat (n) send_item(pick_sample());
    end
  endtask

  initial begin
    build_sine_q16();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_each_type();
    test_corner_settings();
    test_long_stall();
    test_random_traces();
    drain();
    if (errors == 0) begin
      $display("trace_end_taper: match");
    end else begin
      $display("trace_end_taper: mismatch");
    end
    $finish;
  end

endmodule
